@@ sv/key_value_table_linear_unit_macros.svh @@
// ----------------------------------------------------------------------------
// key_value_table_linear_unit_macros
// Assertion macros for the key/value table.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_LINEAR_UNIT_MACROS_SVH
`define KEY_VALUE_TABLE_LINEAR_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KVT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication with the consequent in the next cycle.
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and constants shared by the linear key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int DEFAULT_ENTRIES = 128;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 63;
   localparam int COUNT_OUT_W     = 8;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key;
      logic [62:0]        value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [62:0] read_value;
      logic [1:0]  status;
      logic [7:0]  entry_count;
   } rsp_type;

   // Control from the sequencer to each cell.
   typedef struct packed {
      logic shift;   // rotate contents one cell toward cell 0
      logic load;    // cell count, just past the ring, takes the incoming pair
   } cell_ctl_type;

endpackage

@@ sv/key_value_table_linear_unit.sv @@
// ----------------------------------------------------------------------------
// key_value_table_linear_unit
// Linear-search key/value table built as a rotating ring of cells.
// ----------------------------------------------------------------------------
// channel | ports                     | beat
// req     | req_valid/ready, req_data | opcode, key, value
// rsp     | rsp_valid/ready, rsp_data | found, read_value, status, entry_count
//
// Add and unknown opcodes go straight to the response; get turns the
// ring once, and remove with a hit turns it twice. The ring rotates one
// cell per cycle and only cell 0 is compared, so the count of stored
// pairs sets the scan length. Synchronous reset empties the table; a
// stalled rsp beat holds off the next req beat.
module key_value_table_linear_unit
   import kvt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
`include "key_value_table_linear_unit_macros.svh"

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = $clog2(ENTRIES);

   cell_ctl_type       ctl;
   cell_ctl_type       cctl [ENTRIES];
   logic               feed_sel;
   logic [KEY_W-1:0]   feed_key;
   logic [VALUE_W-1:0] feed_value;
   logic [CNT_W-1:0]   count;
   logic [KEY_W-1:0]   ckey [ENTRIES];
   logic [VALUE_W-1:0] cval [ENTRIES];
   logic [KEY_W-1:0]   pkey [ENTRIES];
   logic [VALUE_W-1:0] pval [ENTRIES];
   logic               full_add;

   kvt_ctrl #(.ENTRIES(ENTRIES), .CNT_W(CNT_W)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .head_key(ckey[0]), .head_value(cval[0]),
      .ctl, .feed_sel, .feed_key, .feed_value, .count_out(count)
   );

   // Ring of length count: cell i takes cell i+1; cell count-1 takes the
   // feed (head wrap-around, or a new/replacement pair). Load feeds cell count.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic is_tail;
      logic is_new;
      assign is_tail = (CNT_W'(i) == count - CNT_W'(1));
      assign is_new  = (CNT_W'(i) == count);
      always_comb begin
         cctl[i] = '0;
         cctl[i].shift = ctl.shift && (CNT_W'(i) < count);
         cctl[i].load  = ctl.load && is_new;
         if (is_tail || is_new) begin
            pkey[i] = feed_key;
            pval[i] = feed_value;
         end else if (i + 1 < ENTRIES) begin
            pkey[i] = ckey[IDX_W'((i + 1) % ENTRIES)];
            pval[i] = cval[IDX_W'((i + 1) % ENTRIES)];
         end else begin
            pkey[i] = feed_key;
            pval[i] = feed_value;
         end
      end
      kvt_cell u_cell (
         .clock, .ctl(cctl[i]), .key_prev(pkey[i]), .value_prev(pval[i]),
         .key_out(ckey[i]), .value_out(cval[i])
      );
   end

   assign full_add = req_valid && req_ready && req_data.opcode == OP_ADD
                     && count == CNT_W'(ENTRIES);

   `KVT_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count <= CNT_W'(ENTRIES), "count overflow")
   `KVT_ASSERT_IMP(a_excl, clock, reset, 1'b1, !(req_ready && rsp_valid), "busy overlap")
   `KVT_ASSERT_IMP(a_feed, clock, reset, ctl.load, feed_sel, "load without feed")
   `KVT_ASSERT_NEXT(a_full, clock, reset, full_add, rsp_valid && rsp_data.status == ST_FULL, "full add")

endmodule

@@ sv/kvt_cell.sv @@
// ----------------------------------------------------------------------------
// kvt_cell
// One slot of the rotating key/value ring.
// ----------------------------------------------------------------------------
module kvt_cell
   import kvt_pkg::*;
(
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic [KEY_W-1:0]    key_prev,
   input  logic [VALUE_W-1:0]  value_prev,
   output logic [KEY_W-1:0]    key_out,
   output logic [VALUE_W-1:0]  value_out
);

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.shift || ctl.load) begin
         key_in   = key_prev;
         value_in = value_prev;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

@@ sv/kvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer: rotates the ring past cell 0 to scan or remove; loads on add.
// ----------------------------------------------------------------------------
module kvt_ctrl
   import kvt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES,
   parameter int CNT_W   = $clog2(ENTRIES + 1)
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic [KEY_W-1:0]   head_key,
   input  logic [VALUE_W-1:0] head_value,
   output cell_ctl_type       ctl,
   output logic               feed_sel,
   output logic [KEY_W-1:0]   feed_key,
   output logic [VALUE_W-1:0] feed_value,
   output logic [CNT_W-1:0]   count_out
);
   // Ring holds count entries in cells 0..count-1 (logical order rotates).
   // A full rotation of count steps restores position. Scan: rotate count
   // times, watching cell 0; the first match is the lowest logical slot.
   // Remove: on rotation, drop the matched entry and re-insert the last at
   // its place. Implemented as: rotate ring of length count; when the head
   // is the match, replace it by the final entry, which is moved later.
   // Simpler equivalent used here: remove = ring rotation with the matched
   // entry overwritten by the saved last entry when the matched one passes.

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIX  = 2'd2;
   localparam logic [1:0] S_RSP  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic               hitv_ff, hitv_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [VALUE_W-1:0] hval_ff, hval_in;
   logic [KEY_W-1:0]   lkey_ff, lkey_in;
   logic [VALUE_W-1:0] lval_ff, lval_in;
   logic [CNT_W-1:0]   last_idx;

   assign last_idx  = count_ff - CNT_W'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;
   assign count_out = count_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      hit_in   = hit_ff;
      hitv_in  = hitv_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      hval_in  = hval_ff;
      lkey_in  = lkey_ff;
      lval_in  = lval_ff;
      ctl      = '0;
      feed_sel = 1'b0;
      feed_key   = head_key;
      feed_value = head_value;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               step_in = '0;
               hitv_in = 1'b0;
               rsp_in  = '0;
               if (req_data.opcode == OP_ADD) begin
                  if (count_ff >= CNT_W'(ENTRIES)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ctl.load   = 1'b1;
                     feed_sel   = 1'b1;
                     feed_key   = req_data.key;
                     feed_value = req_data.value;
                     count_in   = count_ff + CNT_W'(1);
                  end
                  rsp_in.entry_count = COUNT_OUT_W'(count_in);
                  state_in = S_RSP;
               end else if ((req_data.opcode inside {OP_GET, OP_REMOVE})
                            && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  if (req_data.opcode != OP_NONE) rsp_in.status = ST_MISSING;
                  rsp_in.entry_count = COUNT_OUT_W'(count_ff);
                  state_in = S_RSP;
               end
            end
         end
         S_SCAN: begin
            // Head holds logical slot step; one full turn of count steps.
            if (!hitv_ff && head_key == req_ff.key) begin
               hitv_in = 1'b1;
               hit_in  = step_ff;
               hval_in = head_value;
            end
            if (step_ff == last_idx) begin
               lkey_in = head_key;
               lval_in = head_value;
            end
            ctl.shift = 1'b1;
            step_in   = step_ff + CNT_W'(1);
            if (step_ff == last_idx) begin
               step_in = '0;
               state_in = (req_ff.opcode == OP_REMOVE && hitv_in) ? S_FIX : S_RSP;
               rsp_in.found = hitv_in;
               rsp_in.status = hitv_in ? ST_OK : ST_MISSING;
               rsp_in.read_value = (req_ff.opcode == OP_GET && hitv_in) ? hval_in : '0;
               rsp_in.entry_count = COUNT_OUT_W'(count_ff);
            end
         end
         S_FIX: begin
            // Second turn: overwrite hit slot with last; the final shift puts
            // the last pair in the tail cell, which then leaves the ring.
            ctl.shift = 1'b1;
            if (step_ff == hit_ff) begin
               feed_sel   = 1'b1;
               feed_key   = lkey_ff;
               feed_value = lval_ff;
            end
            step_in = step_ff + CNT_W'(1);
            if (step_ff == last_idx) begin
               count_in  = last_idx;
               rsp_in.entry_count = COUNT_OUT_W'(last_idx);
               state_in  = S_RSP;
            end
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         hitv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hitv_ff  <= hitv_in;
      end
      step_ff <= step_in;
      hit_ff  <= hit_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      hval_ff <= hval_in;
      lkey_ff <= lkey_in;
      lval_ff <= lval_in;
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear key/value table: directed corner beats,
// then random add/get/remove traffic from a small key pool, checked against
// an in-bench table model under several sender/receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import kvt_pkg::*;

   localparam int DEPTH = DEFAULT_ENTRIES;

   class kv_scoreboard;
      logic [31:0] keys[DEPTH];
      logic [62:0] vals[DEPTH];
      int          count;
      rsp_type     pending[$];
      int          errors;
      int          checked;

      function void note_request(req_type r);
         rsp_type e;
         int      hit;
         e = '0;
         hit = -1;
         if (r.opcode == OP_GET || r.opcode == OP_REMOVE) begin
            for (int i = count - 1; i >= 0; i--) begin
               if (keys[i] == r.key) hit = i;
            end
         end
         if (r.opcode == OP_ADD) begin
            if (count >= DEPTH) begin
               e.status = ST_FULL;
            end else begin
               keys[count] = r.key;
               vals[count] = r.value;
               count++;
            end
         end else if (r.opcode == OP_GET) begin
            if (hit >= 0) begin
               e.found = 1'b1;
               e.read_value = vals[hit];
            end else begin
               e.status = ST_MISSING;
            end
         end else if (r.opcode == OP_REMOVE) begin
            if (hit >= 0) begin
               keys[hit] = keys[count - 1];
               vals[hit] = vals[count - 1];
               count--;
               e.found = 1'b1;
            end else begin
               e.status = ST_MISSING;
            end
         end
         e.entry_count = count[7:0];
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.found !== e.found)
            $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
         if (a.read_value !== e.read_value)
            $display("%0t: read_value exp %h got %h", $time, e.read_value, a.read_value);
         if (a.status !== e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
         if (a.entry_count !== e.entry_count)
            $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                     a.entry_count);
         if (a !== e) errors++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   kv_scoreboard table_model;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           beats_sent;
   logic [31:0]  key_pool[16];

   key_value_table_linear_unit #(.ENTRIES(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("FAIL key_value_table_linear_unit");
      $finish;
   end

   // receiver: random stalls, checks each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) table_model.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // valid stays up after an accept until the next beat or an idle cycle
   task automatic send_beat(logic [1:0] op, logic [31:0] k, logic [62:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, key: k, value: v};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_model.note_request(req_data);
      beats_sent++;
   endtask

   function automatic logic [62:0] rand_value();
      return 63'({$urandom(), $urandom()});
   endfunction

   task automatic random_beats(int n);
      logic [1:0]  op;
      logic [31:0] k;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: op = OP_ADD;
            4, 5, 6:    op = OP_GET;
            7, 8:       op = OP_REMOVE;
            default:    op = OP_NONE;
         endcase
         k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
         send_beat(op, k, rand_value());
      end
   endtask

   initial begin
      table_model = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      foreach (key_pool[i]) key_pool[i] = $urandom();
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, fill to full, drain
      send_beat(OP_GET, 32'h0, '0);
      send_beat(OP_REMOVE, 32'h8000_0000, '0);
      send_beat(OP_NONE, 32'hFFFF_FFFF, '1);
      send_beat(OP_ADD, 32'h8000_0000, '1);
      send_beat(OP_ADD, 32'h7FFF_FFFF, '0);
      send_beat(OP_ADD, 32'h8000_0000, 63'h5555_5555_5555_5555);
      send_beat(OP_GET, 32'h8000_0000, '0);
      send_beat(OP_GET, 32'h7FFF_FFFF, '1);
      send_beat(OP_REMOVE, 32'h8000_0000, '0);
      send_beat(OP_GET, 32'h8000_0000, '0);
      send_beat(OP_REMOVE, 32'h8000_0000, '0);
      send_beat(OP_REMOVE, 32'h7FFF_FFFF, '0);
      for (int i = 0; i < DEPTH + 2; i++) send_beat(OP_ADD, i, rand_value());
      send_beat(OP_GET, DEPTH - 1, '0);
      send_beat(OP_REMOVE, 0, '0);
      for (int i = DEPTH - 1; i > 0; i--) send_beat(OP_REMOVE, i, '0);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
            3:       begin send_idle_pct = 20; recv_stall_pct = 20; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         random_beats(136);
      end
      req_valid <= 1'b0;

      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      $display("Sent %0d beats, checked %0d responses (add/get/remove/unused,",
               beats_sent, table_model.checked);
      $display("full and empty table, duplicate keys, five idling phases).");
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("PASS key_value_table_linear_unit");
      else
         $display("FAIL key_value_table_linear_unit");
      $finish;
   end
endmodule
